// ===== src/i2a_pkg.sv =====
// Shared constants, types and helpers for the integer to ASCII formatter.
`default_nettype none
package i2a_pkg;

  localparam int VALUE_W    = 32;
  localparam int OP_W       = 2;
  localparam int WIDTH_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int DIG_W      = 4;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int DIGS_W     = DEC_DIGITS * DIG_W;
  localparam int BITCNT_W   = $clog2(VALUE_W);

  localparam logic [OP_W-1:0] OP_SDEC = 2'd0;
  localparam logic [OP_W-1:0] OP_UDEC = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_DIGIT_BASE = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_HEX_BASE   = 8'd55;
  localparam logic [CHAR_W-1:0] ASCII_MINUS      = 8'd45;

  localparam logic [WIDTH_W-1:0] DEC_COUNT = WIDTH_W'(DEC_DIGITS);
  localparam logic [WIDTH_W-1:0] HEX_COUNT = WIDTH_W'(HEX_DIGITS);

  typedef struct packed {
    logic                 valid;
    logic [DIGS_W-1:0]    digits;
    logic [WIDTH_W-1:0]   count;
    logic                 neg;
    logic                 fixed;
    logic [WIDTH_W-1:0]   width;
  } i2a_digits_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] base;
    base = (d < 4'd10) ? ASCII_DIGIT_BASE : ASCII_HEX_BASE;
    return base + CHAR_W'(d);
  endfunction

endpackage
`default_nettype wire

// ===== src/i2a_conv.sv =====
// Bit-serial binary to BCD converter, with direct nibble load for hex.
`default_nettype none
module i2a_conv (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           go,
  input  wire logic [i2a_pkg::OP_W-1:0]       op,
  input  wire logic [i2a_pkg::VALUE_W-1:0]    value,
  input  wire logic [i2a_pkg::WIDTH_W-1:0]    width,
  output logic                                busy,
  output i2a_pkg::i2a_digits_t                dig
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CONV = 1'b1;

  logic                                state_r, state_nxt;
  logic [i2a_pkg::VALUE_W-1:0]         bin_r, bin_nxt;
  logic [i2a_pkg::DIGS_W-1:0]          bcd_r, bcd_nxt;
  logic [i2a_pkg::BITCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                                neg_r, neg_nxt;
  logic                                fixed_r, fixed_nxt;
  logic [i2a_pkg::WIDTH_W-1:0]         width_r, width_nxt;
  i2a_pkg::i2a_digits_t                out_r, out_nxt;
  logic [i2a_pkg::DIGS_W-1:0]          adj;
  logic [i2a_pkg::WIDTH_W-1:0]         wclamp;
  logic                                is_neg;

  always_comb begin
    for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
      adj[i*i2a_pkg::DIG_W +: i2a_pkg::DIG_W] =
        (bcd_r[i*i2a_pkg::DIG_W +: i2a_pkg::DIG_W] >= 4'd5) ?
        bcd_r[i*i2a_pkg::DIG_W +: i2a_pkg::DIG_W] + 4'd3 :
        bcd_r[i*i2a_pkg::DIG_W +: i2a_pkg::DIG_W];
    end
  end

  always_comb begin
    if (op == i2a_pkg::OP_HEX) begin
      wclamp = (width > i2a_pkg::HEX_COUNT) ? i2a_pkg::HEX_COUNT : width;
    end else begin
      wclamp = (width > i2a_pkg::DEC_COUNT) ? i2a_pkg::DEC_COUNT : width;
    end
    is_neg = (op == i2a_pkg::OP_SDEC) && value[i2a_pkg::VALUE_W-1];
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    fixed_nxt = fixed_r;
    width_nxt = width_r;
    out_nxt   = out_r;
    out_nxt.valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          neg_nxt   = is_neg;
          fixed_nxt = (op != i2a_pkg::OP_SDEC);
          width_nxt = wclamp;
          if (op == i2a_pkg::OP_HEX) begin
            out_nxt.valid  = 1'b1;
            out_nxt.digits = {value, {(i2a_pkg::DIGS_W - i2a_pkg::VALUE_W){1'b0}}};
            out_nxt.count  = i2a_pkg::HEX_COUNT;
            out_nxt.neg    = 1'b0;
            out_nxt.fixed  = 1'b1;
            out_nxt.width  = wclamp;
          end else begin
            bin_nxt   = is_neg ? (~value + 1'b1) : value;
            bcd_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        {bcd_nxt, bin_nxt} = {adj, bin_r} << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {i2a_pkg::BITCNT_W{1'b1}}) begin
          out_nxt.valid  = 1'b1;
          out_nxt.digits = {adj[i2a_pkg::DIGS_W-2:0], bin_r[i2a_pkg::VALUE_W-1]};
          out_nxt.count  = i2a_pkg::DEC_COUNT;
          out_nxt.neg    = neg_r;
          out_nxt.fixed  = fixed_r;
          out_nxt.width  = width_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_r.valid <= out_nxt.valid;
    end
    bin_r        <= bin_nxt;
    bcd_r        <= bcd_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    fixed_r      <= fixed_nxt;
    width_r      <= width_nxt;
    out_r.digits <= out_nxt.digits;
    out_r.count  <= out_nxt.count;
    out_r.neg    <= out_nxt.neg;
    out_r.fixed  <= out_nxt.fixed;
    out_r.width  <= out_nxt.width;
  end

  assign busy = (state_r == S_CONV);
  assign dig  = out_r;

endmodule
`default_nettype wire

// ===== src/i2a_emit.sv =====
// Digit shifter that drops leading zeros and emits one character per beat.
`default_nettype none
module i2a_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire i2a_pkg::i2a_digits_t          dig,
  output logic                               busy,
  output logic                               strobe,
  output logic [i2a_pkg::CHAR_W-1:0]         ascii_char,
  output logic                               last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MINUS = 2'd1;
  localparam logic [1:0] S_SKIP  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [i2a_pkg::DIGS_W-1:0]       dig_r, dig_nxt;
  logic [i2a_pkg::WIDTH_W-1:0]      rem_r, rem_nxt;
  logic [i2a_pkg::WIDTH_W-1:0]      wid_r, wid_nxt;
  logic                             fixed_r, fixed_nxt;
  logic                             strobe_r, strobe_nxt;
  logic [i2a_pkg::CHAR_W-1:0]       char_r, char_nxt;
  logic                             last_r, last_nxt;
  logic [i2a_pkg::DIG_W-1:0]        top;
  logic                             drop;
  logic                             fin;

  assign top  = dig_r[i2a_pkg::DIGS_W-1 -: i2a_pkg::DIG_W];
  assign drop = (top == '0) && (rem_r > 4'd1) && (!fixed_r || (rem_r > wid_r));
  assign fin  = fixed_r ? (wid_r == 4'd1) : (rem_r == 4'd1);

  always_comb begin
    state_nxt  = state_r;
    dig_nxt    = dig_r;
    rem_nxt    = rem_r;
    wid_nxt    = wid_r;
    fixed_nxt  = fixed_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (dig.valid) begin
          dig_nxt   = dig.digits;
          rem_nxt   = dig.count;
          wid_nxt   = dig.width;
          fixed_nxt = dig.fixed;
          state_nxt = dig.neg ? S_MINUS : S_SKIP;
        end
      end
      S_MINUS: begin
        strobe_nxt = 1'b1;
        char_nxt   = i2a_pkg::ASCII_MINUS;
        last_nxt   = 1'b0;
        state_nxt  = S_SKIP;
      end
      S_SKIP: begin
        if (drop) begin
          dig_nxt = dig_r << i2a_pkg::DIG_W;
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        strobe_nxt = 1'b1;
        char_nxt   = i2a_pkg::digit_char(top);
        last_nxt   = fin;
        dig_nxt    = dig_r << i2a_pkg::DIG_W;
        rem_nxt    = rem_r - 1'b1;
        wid_nxt    = wid_r - 1'b1;
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    dig_r   <= dig_nxt;
    rem_r   <= rem_nxt;
    wid_r   <= wid_nxt;
    fixed_r <= fixed_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign strobe     = strobe_r;
  assign ascii_char = char_r;
  assign last       = last_r;

endmodule
`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
// Decimal: shift-and-add-3 over every input bit, a hand-off to the emitter, a step per dropped
// leading zero, a step to find the first digit, then each character, after a '-' if negative.
// Hex: nibbles load directly, then the same drop and emit steps. Digits leave one a cycle on
// out_strobe, cannot be held off, and busy drops as the last one is issued; operation three, or a
// zero width in unsigned decimal or hex, emits nothing. Sync active-low reset idles all.
`default_nettype none
module integer_to_ascii_formatter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [i2a_pkg::OP_W-1:0]     in_operation,
  input  wire logic [i2a_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [i2a_pkg::WIDTH_W-1:0]  in_width,
  output logic                              out_strobe,
  output logic [i2a_pkg::CHAR_W-1:0]        out_ascii_char,
  output logic                              out_last
);

  i2a_pkg::i2a_digits_t dig;
  logic                 conv_busy;
  logic                 emit_busy;
  logic                 accept;
  logic                 go;

  assign busy   = conv_busy | emit_busy | dig.valid;
  assign accept = start & ~busy;
  assign go     = accept
                  && (in_operation == i2a_pkg::OP_SDEC
                      || ((in_operation == i2a_pkg::OP_UDEC || in_operation == i2a_pkg::OP_HEX)
                          && in_width != '0));

  i2a_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .op    (in_operation),
    .value (in_value),
    .width (in_width),
    .busy  (conv_busy),
    .dig   (dig)
  );

  i2a_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .dig        (dig),
    .busy       (emit_busy),
    .strobe     (out_strobe),
    .ascii_char (out_ascii_char),
    .last       (out_last)
  );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the integer to ASCII formatter: directed table, then random numbers.
`timescale 1ns / 100ps
module tb_top;

  localparam logic [i2a_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM   = 206;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [i2a_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } char_beat_t;

  typedef struct packed {
    logic [i2a_pkg::OP_W-1:0]    op;
    logic [i2a_pkg::VALUE_W-1:0] value;
    logic [i2a_pkg::WIDTH_W-1:0] width;
    logic                        typed;
    logic [3:0]                  nchars;
    logic [8*11-1:0]             text;
  } number_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic [i2a_pkg::OP_W-1:0]     in_operation = '0;
  logic [i2a_pkg::VALUE_W-1:0]  in_value = '0;
  logic [i2a_pkg::WIDTH_W-1:0]  in_width = '0;
  logic                         busy;
  logic                         out_strobe;
  logic [i2a_pkg::CHAR_W-1:0]   out_ascii_char;
  logic                         out_last;

  char_beat_t  pending_chars [$];
  char_beat_t  head_beat;
  number_row_t directed_rows [NUM_DIRECTED];
  int          errors = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;

  integer_to_ascii_formatter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_width       (in_width),
    .out_strobe     (out_strobe),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic number_row_t mk_row(input logic [i2a_pkg::OP_W-1:0] op,
                                         input logic [i2a_pkg::VALUE_W-1:0] value,
                                         input logic [i2a_pkg::WIDTH_W-1:0] width,
                                         input logic typed, input logic [3:0] nchars,
                                         input logic [8*11-1:0] text);
    number_row_t r;
    r.op = op;
    r.value = value;
    r.width = width;
    r.typed = typed;
    r.nchars = nchars;
    r.text = text;
    return r;
  endfunction

  task automatic format_number(input logic [i2a_pkg::OP_W-1:0] op,
                               input logic [i2a_pkg::VALUE_W-1:0] val,
                               input logic [i2a_pkg::WIDTH_W-1:0] wid);
    logic [i2a_pkg::VALUE_W-1:0] mag;
    logic [i2a_pkg::VALUE_W-1:0] radix;
    logic [i2a_pkg::VALUE_W-1:0] d;
    logic [i2a_pkg::CHAR_W-1:0]  digs [0:9];
    char_beat_t                  beat;
    int                          n;
    int                          w;
    int                          pad;
    int                          i;
    if (op == OP_UNUSED) return;
    mag = val;
    w = int'(wid);
    radix = (op == i2a_pkg::OP_HEX) ? 32'd16 : 32'd10;
    if (op == i2a_pkg::OP_SDEC) begin
      if (val[i2a_pkg::VALUE_W-1]) begin
        mag = -val;
        beat.ch = i2a_pkg::ASCII_MINUS;
        beat.last = 1'b0;
        pending_chars.push_back(beat);
      end
    end else if (op == i2a_pkg::OP_UDEC) begin
      if (w > i2a_pkg::DEC_DIGITS) w = i2a_pkg::DEC_DIGITS;
    end else if (w > i2a_pkg::HEX_DIGITS) begin
      w = i2a_pkg::HEX_DIGITS;
    end
    n = 0;
    do begin
      d = mag % radix;
      digs[n] = (d < 10) ? i2a_pkg::ASCII_DIGIT_BASE + i2a_pkg::CHAR_W'(d)
                         : i2a_pkg::ASCII_HEX_BASE + i2a_pkg::CHAR_W'(d);
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < 10);
    if (op == i2a_pkg::OP_SDEC) w = n;
    pad = (n < w) ? w - n : 0;
    for (i = 0; i < w; i++) begin
      beat.ch = (i < pad) ? i2a_pkg::ASCII_DIGIT_BASE : digs[n - 1 - (i - pad)];
      beat.last = (i == w - 1);
      pending_chars.push_back(beat);
    end
  endtask

  task automatic drive_number(input number_row_t row);
    char_beat_t beat;
    int         gap;
    int         i;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= row.op;
    in_value <= row.value;
    in_width <= row.width;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (row.typed) begin
      for (i = 0; i < row.nchars; i++) begin
        beat.ch = row.text[8*(row.nchars - 1 - i) +: 8];
        beat.last = (i == row.nchars - 1);
        pending_chars.push_back(beat);
      end
    end else begin
      format_number(row.op, row.value, row.width);
    end
  endtask

  function automatic logic [i2a_pkg::VALUE_W-1:0] pick_value();
    logic [i2a_pkg::VALUE_W-1:0] v;
    int                          k;
    v = 32'd1;
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 99999);
      3: begin
        k = $urandom_range(0, 31);
        return (v << k) - $urandom_range(0, 1);
      end
      4: begin
        k = $urandom_range(0, 9);
        repeat (k) v = v * 10;
        return v - $urandom_range(0, 1);
      end
      5: return -$urandom_range(1, 1000);
      default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      ^ $urandom_range(0, 3);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual char 0x%02h last %0b",
                 $time, out_ascii_char, out_last);
      end else begin
        head_beat = pending_chars.pop_front();
        if (out_ascii_char !== head_beat.ch) begin
          errors++;
          $display("%0t: char mismatch, expected 0x%02h, actual 0x%02h",
                   $time, head_beat.ch, out_ascii_char);
        end
        if (out_last !== head_beat.last) begin
          errors++;
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, head_beat.last, out_last);
        end
      end
    end
  end

  initial begin
    number_row_t row;
    int          i;
    int          sel;
    directed_rows[0]  = mk_row(i2a_pkg::OP_SDEC, 32'd0, 4'd1, 1'b1, 4'd1, "0");
    directed_rows[1]  = mk_row(i2a_pkg::OP_SDEC, 32'h7FFF_FFFF, 4'd0, 1'b1, 4'd10,
                               "2147483647");
    directed_rows[2]  = mk_row(i2a_pkg::OP_SDEC, 32'h8000_0000, 4'd15, 1'b1, 4'd11,
                               "-2147483648");
    directed_rows[3]  = mk_row(i2a_pkg::OP_SDEC, 32'hFFFF_FFFF, 4'd5, 1'b1, 4'd2, "-1");
    directed_rows[4]  = mk_row(i2a_pkg::OP_SDEC, 32'd12345, 4'd15, 1'b1, 4'd5, "12345");
    directed_rows[5]  = mk_row(i2a_pkg::OP_UDEC, 32'd0, 4'd1, 1'b1, 4'd1, "0");
    directed_rows[6]  = mk_row(i2a_pkg::OP_UDEC, 32'hFFFF_FFFF, 4'd10, 1'b1, 4'd10,
                               "4294967295");
    directed_rows[7]  = mk_row(i2a_pkg::OP_UDEC, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd10,
                               "4294967295");
    directed_rows[8]  = mk_row(i2a_pkg::OP_UDEC, 32'hFFFF_FFFF, 4'd3, 1'b1, 4'd3, "429");
    directed_rows[9]  = mk_row(i2a_pkg::OP_UDEC, 32'd42, 4'd5, 1'b1, 4'd5, "00042");
    directed_rows[10] = mk_row(i2a_pkg::OP_UDEC, 32'd0, 4'd11, 1'b1, 4'd10, "0000000000");
    directed_rows[11] = mk_row(i2a_pkg::OP_HEX, 32'hFFFF_FFFF, 4'd8, 1'b1, 4'd8, "FFFFFFFF");
    directed_rows[12] = mk_row(i2a_pkg::OP_HEX, 32'hDEAD_BEEF, 4'd15, 1'b1, 4'd8, "DEADBEEF");
    directed_rows[13] = mk_row(i2a_pkg::OP_HEX, 32'hABCD_EF01, 4'd2, 1'b1, 4'd2, "AB");
    directed_rows[14] = mk_row(i2a_pkg::OP_HEX, 32'h0000_001F, 4'd4, 1'b1, 4'd4, "001F");
    directed_rows[15] = mk_row(i2a_pkg::OP_HEX, 32'd0, 4'd1, 1'b1, 4'd1, "0");
    directed_rows[16] = mk_row(i2a_pkg::OP_UDEC, 32'd7, 4'd0, 1'b1, 4'd0, '0);
    directed_rows[17] = mk_row(i2a_pkg::OP_HEX, 32'd7, 4'd0, 1'b1, 4'd0, '0);
    directed_rows[18] = mk_row(OP_UNUSED, 32'd5, 4'd4, 1'b1, 4'd0, '0);
    directed_rows[19] = mk_row(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd0, '0);
    directed_rows[20] = mk_row(i2a_pkg::OP_SDEC, 32'h5A5A_5A5A, 4'd0, 1'b0, 4'd0, '0);
    directed_rows[21] = mk_row(i2a_pkg::OP_UDEC, 32'h0001_E240, 4'd9, 1'b0, 4'd0, '0);
    directed_rows[22] = mk_row(i2a_pkg::OP_HEX, 32'h1234_5678, 4'd6, 1'b1, 4'd6, "123456");
    directed_rows[23] = mk_row(i2a_pkg::OP_SDEC, 32'hFFFF_FF85, 4'd3, 1'b1, 4'd4, "-123");

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) drive_number(directed_rows[i]);

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 15);
      row.op = (sel < 5) ? i2a_pkg::OP_SDEC : (sel < 10) ? i2a_pkg::OP_UDEC
             : (sel < 15) ? i2a_pkg::OP_HEX : OP_UNUSED;
      row.value = pick_value();
      row.width = i2a_pkg::WIDTH_W'($urandom_range(0, 15));
      row.typed = 1'b0;
      row.nchars = '0;
      row.text = '0;
      drive_number(row);
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== integer_to_ascii_formatter.f =====
src/i2a_pkg.sv
src/i2a_conv.sv
src/i2a_emit.sv
src/integer_to_ascii_formatter.sv
bench/tb_top.sv
